// ----- rtl/stop_event_ring_core_macros.svh -----
// Assertion macros for the stop event ring core.
`ifndef STOP_EVENT_RING_CORE_MACROS_SVH
`define STOP_EVENT_RING_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ser_pkg.sv -----
// Shared types and constants for the stop event ring.
package ser_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_POLL  = 2'd1,
    REQ_DROP  = 2'd2,
    REQ_RESET = 2'd3
  } req_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] addr;
    logic [31:0] gen;
    logic [3:0]  kind;
    logic [7:0]  fnum;
    logic [3:0]  tstate;
    logic [7:0]  prio;
    logic [63:0] stamp;
  } slot_t;

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_DEATH_KIND = 1'b0;
  localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;

endpackage

// ----- rtl/ser_slot_ram.sv -----
// Slot store: one write port and one registered read port.
module ser_slot_ram import ser_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/stop_event_ring_core.sv -----
// Stop event ring: bounded event queue with oldest-entry eviction.
//
// Requests arrive on the input channel (in_valid / in_stall); each request
// yields exactly one result word on the output channel (out_valid /
// out_stall). req_type selects enqueue, poll, drop target or store reset.
// A reset request or an enqueue into a free slot goes from the plan step
// straight to the finish step. A poll, a drop, or an enqueue into a full store
// walks every slot through the single read port of the slot RAM, one slot per
// cycle, through one shared stamp comparator, before it finishes.
// One request is in flight at a time; in_stall is high until the sequencer
// is back in idle after the result is committed. A finished result sits in
// the output register, and the next request is accepted meanwhile; it waits
// at its commit step while the receiver holds out_stall. The death kind
// register sits at byte address 0 of the APB port. rst clears the valid
// bits, the stamp (to one), the drop counter and the death kind; slot
// contents need no clearing since a slot is only used while it is valid.
`include "stop_event_ring_core_macros.svh"

module stop_event_ring_core import ser_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [63:0]        task_id,
  input  logic [31:0]        task_gen,
  input  logic [3:0]         kind,
  input  logic [7:0]         trap_num,
  input  logic [63:0]        trap_addr,
  input  logic [3:0]         task_state,
  input  logic [7:0]         task_prio,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic               evicted,
  output logic [63:0]        ev_target_id,
  output logic [31:0]        ev_target_gen,
  output logic [3:0]         ev_kind,
  output logic [7:0]         ev_fault_num,
  output logic [63:0]        ev_fault_addr,
  output logic [3:0]         ev_state,
  output logic [7:0]         ev_prio,
  output logic [31:0]        drop_total,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PLAN   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t          state;
  req_t            req;
  slot_t           item;
  logic [3:0]      death_kind;
  logic [SLOTS-1:0] valid;
  logic [63:0]     next_stamp;
  logic [31:0]     drop_cnt;
  logic [31:0]     drop_cnt_next;
  logic [CW-1:0]   cnt;
  logic            rd_ok;
  logic [IW-1:0]   rd_idx;
  logic            have;
  logic            best_p;
  logic [IW-1:0]   best_idx;
  slot_t           best;
  logic            evict;

  logic            in_fire;
  logic            out_ready;
  logic            commit;
  logic            full;
  logic [IW-1:0]   free_idx;
  logic            rd_en;
  slot_t           rd_data;
  slot_t           wr_data;
  logic            wr_en;
  logic            elig;
  logic            cand_p;
  logic            better;
  logic            cfg_wr;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_ready = !out_valid || !out_stall;
  assign commit    = (state == ST_FINISH) && out_ready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      death_kind <= '0;
    end else if (cfg_wr && (paddr[2] == REG_DEATH_KIND)) begin
      death_kind <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEATH_KIND) ? {28'd0, death_kind} : 32'd0;

  // Free slot search and fill state
  assign full = &valid;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Slot store
  assign rd_en = (state == ST_SCAN) && (cnt < CW'(SLOTS));
  assign wr_en = commit && (req == REQ_ENQ);

  always_comb begin
    wr_data       = item;
    wr_data.stamp = next_stamp;
  end

  ser_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (best_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  // Shared compare unit: one candidate slot per cycle
  always_comb begin
    case (req) inside
      REQ_ENQ: begin
        elig   = 1'b1;
        cand_p = (item.kind == death_kind) ? (rd_data.kind != death_kind) : 1'b1;
      end
      REQ_POLL, REQ_DROP: begin
        elig   = valid[rd_idx] && (rd_data.id == item.id) && (rd_data.gen == item.gen);
        cand_p = 1'b1;
      end
      default: begin
        elig   = 1'b0;
        cand_p = 1'b1;
      end
    endcase
  end

  assign better = rd_ok && elig &&
                  (!have || (cand_p && !best_p) ||
                   ((cand_p == best_p) && (rd_data.stamp < best.stamp)));

  always_comb begin
    drop_cnt_next = drop_cnt;
    if (req == REQ_RESET) begin
      drop_cnt_next = '0;
    end else if ((req == REQ_ENQ) && evict && (drop_cnt != DROP_MAX)) begin
      drop_cnt_next = drop_cnt + 32'd1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_ok <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          rd_ok <= 1'b0;
          if (req == REQ_RESET || (req == REQ_ENQ && !full)) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_ok <= rd_en;
          if (rd_ok && (rd_idx == LAST_IDX)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req         <= req_t'(req_type);
      item.id     <= task_id;
      item.addr   <= trap_addr;
      item.gen    <= task_gen;
      item.kind   <= kind;
      item.fnum   <= trap_num;
      item.tstate <= task_state;
      item.prio   <= task_prio;
      item.stamp  <= '0;
    end
    if (state == ST_PLAN) begin
      cnt      <= '0;
      have     <= 1'b0;
      best_p   <= 1'b0;
      best_idx <= free_idx;
      evict    <= full;
    end
    if (state == ST_SCAN) begin
      if (rd_en) begin
        cnt <= cnt + CW'(1);
      end
      rd_idx <= cnt[IW-1:0];
      if (better) begin
        have     <= 1'b1;
        best_p   <= cand_p;
        best_idx <= rd_idx;
        best     <= rd_data;
      end
    end
  end

  // Store state: valid bits, stamp, drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      next_stamp <= 64'd1;
      drop_cnt   <= '0;
    end else begin
      if ((state == ST_SCAN) && (req == REQ_DROP) && rd_ok && elig) begin
        valid[rd_idx] <= 1'b0;
      end
      if (commit) begin
        drop_cnt <= drop_cnt_next;
        case (req)
          REQ_ENQ: begin
            valid[best_idx] <= 1'b1;
            next_stamp      <= next_stamp + 64'd1;
          end
          REQ_POLL: begin
            if (have) begin
              valid[best_idx] <= 1'b0;
            end
          end
          REQ_RESET: begin
            valid      <= '0;
            next_stamp <= 64'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      found         <= (req == REQ_POLL) && have;
      evicted       <= (req == REQ_ENQ) && evict;
      drop_total    <= drop_cnt_next;
      ev_target_id  <= '0;
      ev_target_gen <= '0;
      ev_kind       <= '0;
      ev_fault_num  <= '0;
      ev_fault_addr <= '0;
      ev_state      <= '0;
      ev_prio       <= '0;
      if ((req == REQ_POLL) && have) begin
        ev_target_id  <= best.id;
        ev_target_gen <= best.gen;
        ev_kind       <= best.kind;
        ev_fault_num  <= best.fnum;
        ev_fault_addr <= best.addr;
        ev_state      <= best.tstate;
        ev_prio       <= best.prio;
      end
    end
  end

  `SER_ASSERT_NEXT(a_accept_plans, in_fire, state == ST_PLAN, "accept did not start planning")
  `SER_ASSERT_NEXT(a_scan_ends, (state == ST_SCAN) && rd_ok && (rd_idx == LAST_IDX), state == ST_FINISH, "scan overran last slot")
  `SER_ASSERT_NOW(a_found_excl, out_valid && found, !evicted, "found and evicted together")
  `SER_ASSERT_NEXT(a_drop_mono, !(commit && (req == REQ_RESET)), drop_cnt >= $past(drop_cnt), "drop counter went down")

endmodule

// ----- tb/tb_stop_event_ring_core.sv -----
// Self-checking testbench for the stop event ring core: random requests, shadow ring, result checks.
module tb_stop_event_ring_core;
  import ser_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    req_t        req;
    logic [63:0] id;
    logic [31:0] gen;
    logic [3:0]  kind;
    logic [7:0]  fnum;
    logic [63:0] addr;
    logic [3:0]  tstate;
    logic [7:0]  prio;
  } stop_req_t;

  typedef struct packed {
    logic        found;
    logic        evicted;
    logic [63:0] id;
    logic [31:0] gen;
    logic [3:0]  kind;
    logic [7:0]  fnum;
    logic [63:0] addr;
    logic [3:0]  tstate;
    logic [7:0]  prio;
    logic [31:0] drops;
  } stop_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  stop_req_t req_word = '0;

  logic        in_stall;
  logic        out_valid;
  logic        found;
  logic        evicted;
  logic [63:0] ev_target_id;
  logic [31:0] ev_target_gen;
  logic [3:0]  ev_kind;
  logic [7:0]  ev_fault_num;
  logic [63:0] ev_fault_addr;
  logic [3:0]  ev_state;
  logic [7:0]  ev_prio;
  logic [31:0] drop_total;
  logic [31:0] prdata;
  logic        pready;

  stop_req_t req_backlog[$];
  stop_res_t result_due[$];

  // shadow of the ring
  slot_t       shadow_slot [RING_SLOTS];
  logic        shadow_valid[RING_SLOTS];
  logic [63:0] shadow_stamp_next;
  logic [31:0] shadow_drops;
  logic [3:0]  death_code;

  logic [63:0] pool_id [4];
  logic [31:0] pool_gen[4];

  int n_sent = 0;
  int n_recv = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int errors = 0;
  int cycles = 0;

  stop_event_ring_core #(.SLOTS(RING_SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_word.req), .task_id(req_word.id), .task_gen(req_word.gen),
    .kind(req_word.kind), .trap_num(req_word.fnum), .trap_addr(req_word.addr),
    .task_state(req_word.tstate), .task_prio(req_word.prio),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .evicted(evicted),
    .ev_target_id(ev_target_id), .ev_target_gen(ev_target_gen), .ev_kind(ev_kind),
    .ev_fault_num(ev_fault_num), .ev_fault_addr(ev_fault_addr), .ev_state(ev_state),
    .ev_prio(ev_prio), .drop_total(drop_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void shadow_clear();
    for (int i = 0; i < RING_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_slot[i] = '0;
    end
    shadow_stamp_next = 64'd1;
    shadow_drops = '0;
  endfunction

  function automatic int oldest_slot(logic skip_death);
    int best;
    best = -1;
    for (int i = 0; i < RING_SLOTS; i++) begin
      if (skip_death && shadow_slot[i].kind == death_code) continue;
      if (best < 0 || shadow_slot[i].stamp < shadow_slot[best].stamp) best = i;
    end
    return best;
  endfunction

  function automatic stop_res_t ring_apply(stop_req_t w);
    stop_res_t r;
    int slot;
    r = '0;
    case (w.req)
      REQ_ENQ: begin
        slot = -1;
        for (int i = 0; i < RING_SLOTS; i++)
          if (!shadow_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          if (w.kind == death_code) slot = oldest_slot(1'b1);
          if (slot < 0) slot = oldest_slot(1'b0);
          r.evicted = 1'b1;
          if (shadow_drops != DROP_MAX) shadow_drops = shadow_drops + 32'd1;
        end
        shadow_slot[slot].id = w.id;
        shadow_slot[slot].addr = w.addr;
        shadow_slot[slot].gen = w.gen;
        shadow_slot[slot].kind = w.kind;
        shadow_slot[slot].fnum = w.fnum;
        shadow_slot[slot].tstate = w.tstate;
        shadow_slot[slot].prio = w.prio;
        shadow_slot[slot].stamp = shadow_stamp_next;
        shadow_stamp_next = shadow_stamp_next + 64'd1;
        shadow_valid[slot] = 1'b1;
      end
      REQ_POLL: begin
        slot = -1;
        for (int i = 0; i < RING_SLOTS; i++) begin
          if (!shadow_valid[i] || shadow_slot[i].id != w.id || shadow_slot[i].gen != w.gen)
            continue;
          if (slot < 0 || shadow_slot[i].stamp < shadow_slot[slot].stamp) slot = i;
        end
        if (slot >= 0) begin
          r.found = 1'b1;
          r.id = shadow_slot[slot].id;
          r.gen = shadow_slot[slot].gen;
          r.kind = shadow_slot[slot].kind;
          r.fnum = shadow_slot[slot].fnum;
          r.addr = shadow_slot[slot].addr;
          r.tstate = shadow_slot[slot].tstate;
          r.prio = shadow_slot[slot].prio;
          shadow_valid[slot] = 1'b0;
        end
      end
      REQ_DROP: begin
        for (int i = 0; i < RING_SLOTS; i++)
          if (shadow_valid[i] && shadow_slot[i].id == w.id && shadow_slot[i].gen == w.gen)
            shadow_valid[i] = 1'b0;
      end
      default: shadow_clear();
    endcase
    r.drops = shadow_drops;
    return r;
  endfunction

  function automatic stop_req_t mk_word(req_t req, logic [63:0] id, logic [31:0] gen,
                                        logic [3:0] kind, logic [7:0] fnum,
                                        logic [63:0] addr, logic [3:0] tstate,
                                        logic [7:0] prio);
    stop_req_t w;
    w.req = req;
    w.id = id;
    w.gen = gen;
    w.kind = kind;
    w.fnum = fnum;
    w.addr = addr;
    w.tstate = tstate;
    w.prio = prio;
    return w;
  endfunction

  // mostly pooled targets so polls and drops hit; some noise ids and generations
  function automatic stop_req_t rand_word();
    stop_req_t w;
    int pick;
    int p;
    pick = $urandom_range(99);
    if (pick < 63) w.req = REQ_ENQ;
    else if (pick < 93) w.req = REQ_POLL;
    else if (pick < 99) w.req = REQ_DROP;
    else w.req = REQ_RESET;
    p = $urandom_range(3);
    w.id = pool_id[p];
    w.gen = pool_gen[p];
    pick = $urandom_range(99);
    if (pick < 8) w.id = {$urandom, $urandom};
    else if (pick < 13) w.gen = $urandom;
    w.kind = ($urandom_range(99) < 35) ? death_code : 4'($urandom);
    w.fnum = 8'($urandom);
    w.addr = {$urandom, $urandom};
    w.tstate = 4'($urandom);
    w.prio = 8'($urandom);
    return w;
  endfunction

  task automatic apb_write(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(REG_DEATH_KIND));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    death_code = value[3:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || result_due.size() != 0);
  endtask

  task automatic check_field(string tag, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, tag, want_v, got_v);
    end
  endtask

  // driver: hold a word until taken, then advance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_due.push_back(ring_apply(req_word));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 &&
            ((n_sent >= 800 && n_sent < 950) || $urandom_range(99) >= 21)) begin
          req_word <= req_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_recv >= 400) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    stop_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_recv <= n_recv + 1;
        if (result_due.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing pending", $time);
        end else begin
          want = result_due.pop_front();
          check_field("found", 64'(want.found), 64'(found));
          check_field("evicted", 64'(want.evicted), 64'(evicted));
          check_field("ev_target_id", want.id, ev_target_id);
          check_field("ev_target_gen", 64'(want.gen), 64'(ev_target_gen));
          check_field("ev_kind", 64'(want.kind), 64'(ev_kind));
          check_field("ev_fault_num", 64'(want.fnum), 64'(ev_fault_num));
          check_field("ev_fault_addr", want.addr, ev_fault_addr);
          check_field("ev_state", 64'(want.tstate), 64'(ev_state));
          check_field("ev_prio", 64'(want.prio), 64'(ev_prio));
          check_field("drop_total", 64'(want.drops), 64'(drop_total));
        end
      end
      out_stall <= (hold_left != 0) ||
                   (!(n_sent >= 800 && n_sent < 950) && $urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] phase_code[4];
    death_code = 4'd0;
    shadow_clear();
    pool_id[0] = '0;
    pool_id[1] = '1;
    pool_id[2] = {$urandom, $urandom};
    pool_id[3] = {$urandom, $urandom};
    pool_gen[0] = '0;
    pool_gen[1] = '1;
    pool_gen[2] = $urandom;
    pool_gen[3] = $urandom;
    phase_code[0] = 4'd0;
    phase_code[1] = 4'd15;
    phase_code[2] = 4'd9;
    phase_code[3] = 4'($urandom);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, all-death eviction, death skipping death, miss, drop, reset
    apb_write(32'd15);
    @(negedge clk);
    req_backlog.push_back(mk_word(REQ_POLL, '0, '0, 4'd0, 8'd0, '0, 4'd0, 8'd0));
    req_backlog.push_back(mk_word(REQ_DROP, '1, '1, 4'hF, 8'hFF, '1, 4'hF, 8'hFF));
    for (int i = 0; i < RING_SLOTS; i++)
      req_backlog.push_back(mk_word(REQ_ENQ, {64{i[0]}}, {32{i[0]}}, 4'd15,
                                    {8{i[0]}}, {64{~i[0]}}, {4{i[0]}}, {8{~i[0]}}));
    req_backlog.push_back(mk_word(REQ_ENQ, '1, '1, 4'd15, 8'hFF, '1, 4'hF, 8'hFF));
    req_backlog.push_back(mk_word(REQ_ENQ, '0, '0, 4'd3, 8'h00, '0, 4'h0, 8'h00));
    req_backlog.push_back(mk_word(REQ_ENQ, '1, '1, 4'd15, 8'h5A, {$urandom, $urandom},
                                  4'hA, 8'hA5));
    req_backlog.push_back(mk_word(REQ_POLL, '1, '1, 4'd0, 8'd0, '0, 4'd0, 8'd0));
    req_backlog.push_back(mk_word(REQ_POLL, '1, '0, 4'd0, 8'd0, '0, 4'd0, 8'd0));
    req_backlog.push_back(mk_word(REQ_DROP, '0, '0, 4'd0, 8'd0, '0, 4'd0, 8'd0));
    req_backlog.push_back(mk_word(REQ_RESET, '1, '1, 4'hF, 8'hFF, '1, 4'hF, 8'hFF));
    req_backlog.push_back(mk_word(REQ_ENQ, pool_id[2], pool_gen[2], 4'd1, 8'h33,
                                  {$urandom, $urandom}, 4'h5, 8'h77));
    req_backlog.push_back(mk_word(REQ_POLL, pool_id[2], pool_gen[2], 4'd0, 8'd0, '0,
                                  4'd0, 8'd0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      apb_write({28'd0, phase_code[ph]});
      @(negedge clk);
      repeat (312) req_backlog.push_back(rand_word());
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && result_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
